// File: rtl/i2c_target_register_file_unit_defines.svh
// ----------------------------------------------------------------------------
// i2c target register file assertion macros
// shared concurrent assertion forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef I2C_TARGET_REGISTER_FILE_UNIT_DEFINES_SVH
`define I2C_TARGET_REGISTER_FILE_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define I2CTRF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2c target register file port check failed");

// next-cycle implication, disabled in reset
`define I2CTRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2c target register file port check failed");

`endif

// File: rtl/i2ctrf_pkg.sv
// ----------------------------------------------------------------------------
// i2c target register file package
// bus event codes and sequencer states
// ----------------------------------------------------------------------------
package i2ctrf_pkg;

   // bus event codes carried on req_kind
   typedef enum logic [2:0] {
      KIND_WR_ADDR = 3'd0,
      KIND_DATA_RX = 3'd1,
      KIND_STOP    = 3'd2,
      KIND_RD_ADDR = 3'd3,
      KIND_TX_ACK  = 3'd4,
      KIND_LOAD    = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REPLY
   } state_type;

endpackage

// File: rtl/i2c_target_register_file_unit.sv
// ----------------------------------------------------------------------------
// i2c target register file unit
// byte-level register pointer interface with a write store and a read store
// ----------------------------------------------------------------------------
// Every request passes through the accept edge, an execute cycle in which
// the pointer registers update and the stores are read and written through
// their synchronous write and read ports, and a reply cycle in which
// rsp_strobe is high and the result sits on the rsp_ ports. busy stays high
// through the execute and reply cycles, so a new start is taken only once the
// sequencer is back in idle; the registered store reads put a reply cycle
// after the execute cycle. The receiver cannot stall, and each result is
// shown for that single reply cycle only. Both stores read as zero after
// reset through per-entry valid flags cleared at once by reset, so there is
// no clearing pass and requests are taken in the first cycle after reset.
// ----------------------------------------------------------------------------
module i2c_target_register_file_unit #(
   parameter int STORE_DEPTH  = 32,
   parameter int SELECT_INDEX = 1
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_kind,
   input  logic [7:0] req_data_byte,
   input  logic [4:0] req_load_index,
   output logic       rsp_strobe,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic [7:0] rsp_channel_select,
   output logic [7:0] rsp_bytes_received
);

   localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam logic [8:0] DEPTH9 = 9'(STORE_DEPTH);
   // select entry may lie past the end of a small store
   localparam bit SEL_IN_RANGE = (SELECT_INDEX < STORE_DEPTH);
   localparam logic [IDX_W-1:0] SEL_ADDR = IDX_W'(SEL_IN_RANGE ? SELECT_INDEX : 0);

   // sequencer
   i2ctrf_pkg::state_type state_ff, state_in;

   // captured request
   logic [2:0] kind_ff;
   logic [7:0] byte_ff;
   logic [4:0] idx_ff;

   // pointer and transfer state
   logic [7:0] ptr_ff, ptr_in;
   logic [7:0] woff_ff, woff_in;
   logic [7:0] roff_ff, roff_in;
   logic       in_xfer_ff, in_xfer_in;
   logic       expect_ff, expect_in;
   logic [7:0] rx_cnt_ff, rx_cnt_in;
   logic [7:0] sel_ff, sel_in;

   // stores and their valid flags
   logic [7:0] wr_mem [STORE_DEPTH];
   logic [7:0] rd_mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] wr_vld_ff, wr_vld_in;
   logic [STORE_DEPTH-1:0] rd_vld_ff, rd_vld_in;

   // store port controls for the execute cycle
   logic             wr_we;
   logic [IDX_W-1:0] wr_addr;
   logic             rd_we;
   logic [IDX_W-1:0] rd_waddr;
   logic [IDX_W-1:0] rd_raddr;

   // registered read results, consumed in the reply cycle
   logic [7:0] rd_data_ff;
   logic       rd_hit_ff, rd_hit_in;
   logic       tx_flag_ff, tx_flag_in;
   logic [7:0] sel_rd_ff;
   logic       sel_rd_vld_ff;
   logic       sel_fwd_ff, sel_fwd_in;
   logic       sel_upd_ff, sel_upd_in;

   // execute-cycle helpers
   logic [8:0] pos;
   logic       pos_ok;
   logic [7:0] woff_wrap;
   logic       ptr_byte;
   logic       load_ok;
   logic [7:0] new_sel;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         i2ctrf_pkg::ST_IDLE: begin
            if (start) state_in = i2ctrf_pkg::ST_EXEC;
         end
         i2ctrf_pkg::ST_EXEC:  state_in = i2ctrf_pkg::ST_REPLY;
         i2ctrf_pkg::ST_REPLY: state_in = i2ctrf_pkg::ST_IDLE;
         default:              state_in = i2ctrf_pkg::ST_IDLE;
      endcase
   end

   // handshake outputs, no request is taken while reset is high
   always_comb begin
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         i2ctrf_pkg::ST_IDLE:  busy = 1'b0;
         i2ctrf_pkg::ST_EXEC:  busy = 1'b1;
         i2ctrf_pkg::ST_REPLY: rsp_strobe = 1'b1;
         default:              busy = 1'b1;
      endcase
      if (reset) busy = 1'b1;
   end

   // read position and write offset wrap
   assign pos       = {1'b0, ptr_ff} + {1'b0, roff_ff};
   assign pos_ok    = (pos < DEPTH9);
   assign woff_wrap = ({1'b0, woff_ff} >= DEPTH9) ? 8'd0 : woff_ff;
   assign ptr_byte  = in_xfer_ff && expect_ff;
   assign load_ok   = ({4'd0, idx_ff} < DEPTH9);

   assign wr_addr  = woff_wrap[IDX_W-1:0];
   assign rd_raddr = pos_ok ? pos[IDX_W-1:0] : '0;
   assign rd_waddr = load_ok ? IDX_W'(idx_ff) : '0;

   // event decode in the execute cycle
   always_comb begin
      ptr_in     = ptr_ff;
      woff_in    = woff_ff;
      roff_in    = roff_ff;
      in_xfer_in = in_xfer_ff;
      expect_in  = expect_ff;
      rx_cnt_in  = rx_cnt_ff;
      wr_we      = 1'b0;
      rd_we      = 1'b0;
      rd_hit_in  = rd_hit_ff;
      tx_flag_in = tx_flag_ff;
      sel_fwd_in = sel_fwd_ff;
      sel_upd_in = sel_upd_ff;
      if (state_ff == i2ctrf_pkg::ST_EXEC) begin
         rd_hit_in  = 1'b0;
         tx_flag_in = 1'b0;
         sel_fwd_in = 1'b0;
         sel_upd_in = 1'b0;
         unique case (kind_ff)
            i2ctrf_pkg::KIND_WR_ADDR: begin
               rx_cnt_in  = 8'd0;
               woff_in    = 8'd0;
               roff_in    = 8'd0;
               in_xfer_in = 1'b1;
               expect_in  = 1'b1;
            end
            i2ctrf_pkg::KIND_DATA_RX: begin
               if (ptr_byte) begin
                  // pointer beyond the store depth falls back to zero; one equal to it is kept
                  ptr_in    = ({1'b0, byte_ff} > DEPTH9) ? 8'd0 : byte_ff;
                  woff_in   = ({1'b0, byte_ff} > DEPTH9) ? 8'd0 : byte_ff;
                  expect_in = 1'b0;
               end else begin
                  wr_we      = 1'b1;
                  woff_in    = woff_wrap + 8'd1;
                  rx_cnt_in  = rx_cnt_ff + 8'd1;
                  sel_upd_in = 1'b1;
                  // forward the byte when it lands on the select entry
                  sel_fwd_in = SEL_IN_RANGE && (wr_addr == SEL_ADDR);
               end
            end
            i2ctrf_pkg::KIND_STOP: begin
               in_xfer_in = 1'b0;
            end
            i2ctrf_pkg::KIND_RD_ADDR,
            i2ctrf_pkg::KIND_TX_ACK: begin
               tx_flag_in = 1'b1;
               if (pos_ok) begin
                  rd_hit_in = rd_vld_ff[rd_raddr];
                  roff_in   = roff_ff + 8'd1;
               end
            end
            i2ctrf_pkg::KIND_LOAD: begin
               rd_we = load_ok;
            end
            default: begin
               // unused codes leave the pointer and store state alone
               tx_flag_in = 1'b0;
            end
         endcase
      end
   end

   // valid flags follow the store writes
   always_comb begin
      wr_vld_in = wr_vld_ff;
      rd_vld_in = rd_vld_ff;
      if (wr_we) wr_vld_in[wr_addr] = 1'b1;
      if (rd_we) rd_vld_in[rd_waddr] = 1'b1;
   end

   // select value as of the last data write
   always_comb begin
      if (!SEL_IN_RANGE) begin
         new_sel = 8'd0;
      end else if (sel_fwd_ff) begin
         new_sel = byte_ff;
      end else if (sel_rd_vld_ff) begin
         new_sel = sel_rd_ff;
      end else begin
         new_sel = 8'd0;
      end
   end

   always_comb begin
      sel_in = sel_ff;
      if (state_ff == i2ctrf_pkg::ST_REPLY && sel_upd_ff) sel_in = new_sel;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= i2ctrf_pkg::ST_IDLE;
         ptr_ff     <= 8'd0;
         woff_ff    <= 8'd0;
         roff_ff    <= 8'd0;
         in_xfer_ff <= 1'b0;
         expect_ff  <= 1'b0;
         rx_cnt_ff  <= 8'd0;
         sel_ff     <= 8'd0;
         wr_vld_ff  <= '0;
         rd_vld_ff  <= '0;
         rd_hit_ff  <= 1'b0;
         tx_flag_ff <= 1'b0;
         sel_fwd_ff <= 1'b0;
         sel_upd_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ptr_ff     <= ptr_in;
         woff_ff    <= woff_in;
         roff_ff    <= roff_in;
         in_xfer_ff <= in_xfer_in;
         expect_ff  <= expect_in;
         rx_cnt_ff  <= rx_cnt_in;
         sel_ff     <= sel_in;
         wr_vld_ff  <= wr_vld_in;
         rd_vld_ff  <= rd_vld_in;
         rd_hit_ff  <= rd_hit_in;
         tx_flag_ff <= tx_flag_in;
         sel_fwd_ff <= sel_fwd_in;
         sel_upd_ff <= sel_upd_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (state_ff == i2ctrf_pkg::ST_IDLE && start) begin
         kind_ff <= req_kind;
         byte_ff <= req_data_byte;
         idx_ff  <= req_load_index;
      end
   end

   // write store: one write, select entry read every cycle
   always_ff @(posedge clock) begin
      if (wr_we) wr_mem[wr_addr] <= byte_ff;
      sel_rd_ff     <= wr_mem[SEL_ADDR];
      sel_rd_vld_ff <= wr_vld_ff[SEL_ADDR];
   end

   // read store: local load write, transmit read
   always_ff @(posedge clock) begin
      if (rd_we) rd_mem[rd_waddr] <= byte_ff;
      rd_data_ff <= rd_mem[rd_raddr];
   end

   // result
   assign rsp_tx_valid       = rsp_strobe && tx_flag_ff;
   assign rsp_tx_byte        = (rsp_strobe && rd_hit_ff) ? rd_data_ff : 8'd0;
   assign rsp_channel_select = sel_upd_ff ? new_sel : sel_ff;
   assign rsp_bytes_received = rx_cnt_ff;

endmodule

// File: rtl/i2ctrf_checker.sv
// ----------------------------------------------------------------------------
// i2c target register file port checker
// timing and result checks seen from the top level ports
// ----------------------------------------------------------------------------
`include "i2c_target_register_file_unit_defines.svh"

module i2ctrf_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [2:0] req_kind,
   input logic [7:0] req_data_byte,
   input logic [4:0] req_load_index,
   input logic       rsp_strobe,
   input logic       rsp_tx_valid,
   input logic [7:0] rsp_tx_byte,
   input logic [7:0] rsp_channel_select,
   input logic [7:0] rsp_bytes_received
);

   logic accept;
   logic tx_req;

   assign accept = start && !busy;
   assign tx_req = (req_kind == i2ctrf_pkg::KIND_RD_ADDR) ||
                   (req_kind == i2ctrf_pkg::KIND_TX_ACK);

   // every taken request is answered by a reply strobe once the execute state has passed
   `I2CTRF_ASSERT_IMPL(a_reply_latency, clock, reset, accept, ##2 rsp_strobe)
   // a reply stands for one cycle only
   `I2CTRF_ASSERT_NEXT(a_reply_single, clock, reset, rsp_strobe, !rsp_strobe)
   // a transmit event always yields a transmit flag
   `I2CTRF_ASSERT_IMPL(a_tx_flag, clock, reset, accept && tx_req, ##2 rsp_tx_valid)
   // no transmit byte outside a transmit reply
   `I2CTRF_ASSERT_IMPL(a_tx_quiet, clock, reset, !rsp_tx_valid, rsp_tx_byte == 8'd0)

endmodule

bind i2c_target_register_file_unit i2ctrf_checker u_i2ctrf_checker (.*);
